/* rtl/core/ole_pkg.sv */
// Shared types, command codes and defaults for the ordered list engine.
package ole_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int VALUE_BITS_DEF = 32;

  localparam logic [2:0] CMD_PUSH_FRONT  = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK   = 3'd1;
  localparam logic [2:0] CMD_INSERT_AFTER = 3'd2;
  localparam logic [2:0] CMD_REMOVE      = 3'd3;
  localparam logic [2:0] CMD_CONTAINS    = 3'd4;
  localparam logic [2:0] CMD_CLEAR       = 3'd5;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] item_value;
    logic signed [31:0] target_value;
  } in_req_t;

  typedef struct packed {
    logic       ok;
    logic       full_refused;
    logic [4:0] entry_count;
    logic       is_empty;
  } out_resp_t;

  // Token handed from one cell to the next.
  typedef struct packed {
    logic tok;
    logic move;
  } hand_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic [2:0] mode;
    logic       clear;
  } bcast_t;

  typedef struct packed {
    logic done;
    logic found;
  } cell_done_t;

endpackage

/* rtl/core/ole_cell.sv */
// One list cell: holds an entry and acts when the walking token reaches it.
module ole_cell #(
  parameter int VALUE_BITS = ole_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ole_pkg::bcast_t       bc,
  input  logic [VALUE_BITS-1:0] key,
  input  logic [VALUE_BITS-1:0] item,
  input  ole_pkg::hand_t        hand_in,
  input  logic [VALUE_BITS-1:0] carry_in,
  input  logic                  nxt_valid,
  input  logic [VALUE_BITS-1:0] nxt_value,
  output logic                  valid_o,
  output logic [VALUE_BITS-1:0] value_o,
  output ole_pkg::hand_t        hand_out,
  output logic [VALUE_BITS-1:0] carry_out,
  output ole_pkg::cell_done_t   done_o
);

  logic                  valid_r, valid_nxt;
  logic [VALUE_BITS-1:0] value_r, value_nxt;
  logic                  tok_r;
  logic                  move_r;
  logic [VALUE_BITS-1:0] carry_r;
  logic                  hit;

  assign hit     = valid_r && (value_r == key);
  assign valid_o = valid_r;
  assign value_o = value_r;

  always_comb begin
    valid_nxt     = valid_r;
    value_nxt     = value_r;
    hand_out      = '0;
    carry_out     = value_r;
    done_o        = '0;
    if (tok_r) begin
      if (!move_r) begin
        case (bc.mode)
          ole_pkg::CMD_PUSH_BACK: begin
            if (valid_r) begin
              hand_out.tok = 1'b1;
            end else begin
              value_nxt    = item;
              valid_nxt    = 1'b1;
              done_o       = '{done: 1'b1, found: 1'b1};
            end
          end
          ole_pkg::CMD_INSERT_AFTER, ole_pkg::CMD_REMOVE, ole_pkg::CMD_CONTAINS: begin
            if (!valid_r) begin
              done_o.done = 1'b1;
            end else if (!hit) begin
              hand_out.tok = 1'b1;
            end else if (bc.mode == ole_pkg::CMD_CONTAINS) begin
              done_o = '{done: 1'b1, found: 1'b1};
            end else if (bc.mode == ole_pkg::CMD_INSERT_AFTER) begin
              hand_out  = '{tok: 1'b1, move: 1'b1};
              carry_out = item;
            end else if (nxt_valid) begin
              // The matching entry is dropped by pulling the tail one cell up.
              value_nxt = nxt_value;
              hand_out  = '{tok: 1'b1, move: 1'b1};
            end else begin
              valid_nxt = 1'b0;
              done_o    = '{done: 1'b1, found: 1'b1};
            end
          end
          default: begin
            done_o.done = 1'b1;
          end
        endcase
      end else if (bc.mode == ole_pkg::CMD_REMOVE) begin
        if (nxt_valid) begin
          value_nxt = nxt_value;
          hand_out  = '{tok: 1'b1, move: 1'b1};
        end else begin
          valid_nxt = 1'b0;
          done_o    = '{done: 1'b1, found: 1'b1};
        end
      end else begin
        // Insertion ripple: take the carried value and pass the old one on.
        value_nxt = carry_r;
        carry_out = value_r;
        if (valid_r) begin
          hand_out = '{tok: 1'b1, move: 1'b1};
        end else begin
          valid_nxt = 1'b1;
          done_o    = '{done: 1'b1, found: 1'b1};
        end
      end
    end
    if (bc.clear) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      tok_r   <= hand_in.tok;
    end
    move_r  <= hand_in.move;
    carry_r <= carry_in;
    value_r <= value_nxt;
  end

endmodule

/* rtl/core/ole_ctrl.sv */
// Command sequencer: launches the token into the cell row, keeps the count, holds the result.
module ole_ctrl #(
  parameter int DEPTH      = ole_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = ole_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ole_pkg::in_req_t      in_req,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ole_pkg::out_resp_t    out_resp,
  input  logic                  any_done,
  input  logic                  any_found,
  input  logic                  tail_tok,
  output ole_pkg::bcast_t       bc,
  output logic [VALUE_BITS-1:0] key,
  output logic [VALUE_BITS-1:0] item,
  output ole_pkg::hand_t        hand0,
  output logic [VALUE_BITS-1:0] carry0
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic                  ok_r, ok_nxt;
  logic                  refused_r, refused_nxt;
  logic [2:0]            mode_r, mode_nxt;
  logic [VALUE_BITS-1:0] key_r, key_nxt;
  logic [VALUE_BITS-1:0] item_r, item_nxt;
  logic                  out_valid_r, out_valid_nxt;
  ole_pkg::out_resp_t    out_resp_r, out_resp_nxt;

  logic [VALUE_BITS+31:0] item_ext, target_ext;
  logic [VALUE_BITS-1:0]  item_in, target_in;
  logic [CW+4:0]          count_ext;

  // Values are kept as their low VALUE_BITS bits, zero-extended when wider.
  assign item_ext   = {{VALUE_BITS{1'b0}}, in_req.item_value};
  assign target_ext = {{VALUE_BITS{1'b0}}, in_req.target_value};
  assign item_in    = item_ext[VALUE_BITS-1:0];
  assign target_in  = target_ext[VALUE_BITS-1:0];
  assign count_ext  = {5'b0, count_r};

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_resp  = out_resp_r;
  assign key       = key_r;
  assign item      = item_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ok_nxt        = ok_r;
    refused_nxt   = refused_r;
    mode_nxt      = mode_r;
    key_nxt       = key_r;
    item_nxt      = item_r;
    out_valid_nxt = out_valid_r;
    out_resp_nxt  = out_resp_r;
    hand0         = '0;
    carry0        = item_in;
    bc.mode       = mode_r;
    bc.clear      = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          mode_nxt    = in_req.cmd;
          key_nxt     = (in_req.cmd == ole_pkg::CMD_INSERT_AFTER) ? target_in : item_in;
          item_nxt    = item_in;
          ok_nxt      = 1'b0;
          refused_nxt = 1'b0;
          state_nxt   = ST_HOLD;
          if (in_req.cmd inside {ole_pkg::CMD_PUSH_FRONT, ole_pkg::CMD_PUSH_BACK,
                                 ole_pkg::CMD_INSERT_AFTER}) begin
            if (count_r == FULL_COUNT) begin
              refused_nxt = 1'b1;
            end else begin
              // A push at the front starts straight in the insertion ripple.
              hand0.tok  = 1'b1;
              hand0.move = (in_req.cmd == ole_pkg::CMD_PUSH_FRONT);
              state_nxt  = ST_RUN;
            end
          end else if (in_req.cmd inside {ole_pkg::CMD_REMOVE, ole_pkg::CMD_CONTAINS}) begin
            hand0.tok = 1'b1;
            state_nxt = ST_RUN;
          end else if (in_req.cmd == ole_pkg::CMD_CLEAR) begin
            bc.clear  = 1'b1;
            count_nxt = '0;
            ok_nxt    = 1'b1;
          end
        end
      end
      ST_RUN: begin
        // A token leaving the last cell means the search ran off the list.
        if (any_done || tail_tok) begin
          ok_nxt    = any_found;
          state_nxt = ST_HOLD;
          if (any_found) begin
            if (mode_r == ole_pkg::CMD_REMOVE) begin
              count_nxt = count_r - CW'(1);
            end else if (mode_r != ole_pkg::CMD_CONTAINS) begin
              count_nxt = count_r + CW'(1);
            end
          end
        end
      end
      ST_HOLD: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt             = 1'b1;
          out_resp_nxt.ok           = ok_r;
          out_resp_nxt.full_refused = refused_r;
          out_resp_nxt.entry_count  = count_ext[4:0];
          out_resp_nxt.is_empty     = (count_r == '0);
          state_nxt                 = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      mode_r      <= ole_pkg::CMD_CLEAR;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      mode_r      <= mode_nxt;
    end
    ok_r       <= ok_nxt;
    refused_r  <= refused_nxt;
    key_r      <= key_nxt;
    item_r     <= item_nxt;
    out_resp_r <= out_resp_nxt;
  end

endmodule

/* rtl/core/ordered_list_engine.sv */
// Top level of the ordered list engine: sequencer plus a row of list cells.
//
// Usage: one request per command on the in_ channel (cmd, item_value,
// target_value); exactly one response per request on the out_ channel
// (ok, full_refused, entry_count, is_empty). Both channels use valid/ready.
// The list is kept compacted and in order in a row of DEPTH cells. A token
// enters the first cell and moves one cell per cycle: it searches for a
// match or for the end of the list, and insertions and removals ripple the
// following entries one cell down or up the row in the same walk.
// For clear, unused codes and refused pushes the sequencer goes straight to
// its hold state and registers the response; the other commands first walk
// the token through the cell row (one cell per cycle).
// Throughput: one command at a time; in_ready is high whenever no command
// is in progress, so a new request is taken while the previous response
// still sits in the output register.
// Reset (synchronous, rst_n low) empties the list and drops any pending
// response. If the receiver stalls, a finished response waits inside the
// block until the output register is free.
module ordered_list_engine #(
  parameter int DEPTH      = ole_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = ole_pkg::VALUE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ole_pkg::in_req_t   in_req,
  output logic               out_valid,
  input  logic               out_ready,
  output ole_pkg::out_resp_t out_resp
);

  ole_pkg::bcast_t       bc;
  logic [VALUE_BITS-1:0] key;
  logic [VALUE_BITS-1:0] item;

  ole_pkg::hand_t        hand_w  [DEPTH+1];
  logic [VALUE_BITS-1:0] carry_w [DEPTH+1];
  logic                  valid_w [DEPTH+1];
  logic [VALUE_BITS-1:0] value_w [DEPTH+1];
  logic [DEPTH-1:0]      done_v;
  logic [DEPTH-1:0]      found_v;

  assign valid_w[DEPTH] = 1'b0;
  assign value_w[DEPTH] = '0;

  ole_ctrl #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_resp  (out_resp),
    .any_done  (|done_v),
    .any_found (|found_v),
    .tail_tok  (hand_w[DEPTH].tok),
    .bc        (bc),
    .key       (key),
    .item      (item),
    .hand0     (hand_w[0]),
    .carry0    (carry_w[0])
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    ole_pkg::cell_done_t cd;

    ole_cell #(
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .bc        (bc),
      .key       (key),
      .item      (item),
      .hand_in   (hand_w[i]),
      .carry_in  (carry_w[i]),
      .nxt_valid (valid_w[i+1]),
      .nxt_value (value_w[i+1]),
      .valid_o   (valid_w[i]),
      .value_o   (value_w[i]),
      .hand_out  (hand_w[i+1]),
      .carry_out (carry_w[i+1]),
      .done_o    (cd)
    );

    assign done_v[i]  = cd.done;
    assign found_v[i] = cd.found;
  end

endmodule

/* rtl/core/ole_checker.sv */
// Port-level checks for the ordered list engine, bound to the top level.
module ole_checker #(
  parameter int DEPTH = ole_pkg::DEPTH_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input ole_pkg::out_resp_t out_resp
);

  // A stalled response keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_resp))
    else $error("response changed while stalled");

  // Only one command is in flight: taking a request closes the input.
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while a command is in progress");

  a_ok_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_resp.ok && out_resp.full_refused))
    else $error("response both succeeded and refused");

  a_refuse_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_resp.full_refused |-> out_resp.entry_count == 5'(DEPTH))
    else $error("refusal while the store is not full");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (DEPTH >= 32) || (out_resp.is_empty == (out_resp.entry_count == 5'd0)))
    else $error("empty flag disagrees with entry count");

endmodule

bind ordered_list_engine ole_checker #(
  .DEPTH (DEPTH)
) u_ole_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_resp  (out_resp)
);
